// File: rtl/core/s2c_pkg.sv
// shared types and constants of the spherical to cartesian converter
package s2c_pkg;

  localparam int CORDIC_WIDTH = 18;
  localparam int PHASE_WIDTH  = 32;
  localparam int TABLE_LEN    = 24;
  localparam int FRAC_BITS    = 15;

  localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 18'sd19898;
  localparam logic signed [CORDIC_WIDTH-1:0] UNIT_POS    = 18'sd32768;
  localparam logic signed [CORDIC_WIDTH-1:0] UNIT_NEG    = -18'sd32768;

  // atan(2^-i), one turn is 2^32
  localparam logic signed [PHASE_WIDTH-1:0] ATAN_STEP [TABLE_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10680350,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // one rotator lane: vector, residual phase and the fold flag
  typedef struct packed {
    logic signed [CORDIC_WIDTH-1:0] x;
    logic signed [CORDIC_WIDTH-1:0] y;
    logic signed [PHASE_WIDTH-1:0]  phase;
    logic                           neg;
  } s2c_lane_t;

endpackage

// File: rtl/core/s2c_if.sv
// valid/ready channel interfaces for polar input and cartesian output
interface s2c_in_if #(
  parameter int RADIUS_WIDTH = 16,
  parameter int ANGLE_WIDTH  = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [RADIUS_WIDTH-1:0]       radius;
  logic [ANGLE_WIDTH-1:0]        azimuth;
  logic signed [ANGLE_WIDTH-1:0] altitude;

  modport source (output valid, output radius, output azimuth, output altitude, input ready);
  modport sink   (input valid, input radius, input azimuth, input altitude, output ready);
endinterface

interface s2c_out_if #(
  parameter int RADIUS_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [RADIUS_WIDTH:0] coord_x;
  logic signed [RADIUS_WIDTH:0] coord_y;
  logic signed [RADIUS_WIDTH:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

// File: rtl/core/s2c_cell.sv
// one cordic rotation cell, two lanes side by side, with its own valid flag
module s2c_cell
  import s2c_pkg::*;
#(
  parameter int STAGE        = 0,
  parameter int RADIUS_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RADIUS_WIDTH-1:0] in_radius,
  input  s2c_lane_t               in_az,
  input  s2c_lane_t               in_alt,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RADIUS_WIDTH-1:0] out_radius,
  output s2c_lane_t               out_az,
  output s2c_lane_t               out_alt
);

  function automatic s2c_lane_t rotate(s2c_lane_t l);
    s2c_lane_t                      r;
    logic signed [CORDIC_WIDTH-1:0] xs;
    logic signed [CORDIC_WIDTH-1:0] ys;
    logic signed [CORDIC_WIDTH-1:0] xv;
    logic signed [CORDIC_WIDTH-1:0] yv;
    logic signed [PHASE_WIDTH-1:0]  pv;
    xv = l.x;
    yv = l.y;
    pv = l.phase;
    xs = xv >>> STAGE;
    ys = yv >>> STAGE;
    r  = l;
    if (!pv[PHASE_WIDTH-1]) begin
      r.x     = xv - ys;
      r.y     = yv + xs;
      r.phase = pv - ATAN_STEP[STAGE];
    end else begin
      r.x     = xv + ys;
      r.y     = yv - xs;
      r.phase = pv + ATAN_STEP[STAGE];
    end
    return r;
  endfunction

  logic advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_radius <= in_radius;
      out_az     <= rotate(in_az);
      out_alt    <= rotate(in_alt);
    end
  end

endmodule

// File: rtl/core/s2c_scale.sv
// clamp, sign fix and the two truncating multiply steps, ending in the output register
module s2c_scale
  import s2c_pkg::*;
#(
  parameter int RADIUS_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RADIUS_WIDTH-1:0] radius,
  input  s2c_lane_t               az,
  input  s2c_lane_t               alt,
  s2c_out_if.source               cart
);

  localparam int OW = RADIUS_WIDTH + 1;
  localparam int PW = OW + CORDIC_WIDTH;
  localparam int NS = 5;
  localparam logic signed [PW-1:0] ROUND_ADJ = PW'((1 << FRAC_BITS) - 1);

  typedef logic signed [CORDIC_WIDTH-1:0] q15_t;
  typedef logic signed [OW-1:0]           coord_t;
  typedef logic signed [PW-1:0]           prod_t;

  function automatic q15_t fix(logic signed [CORDIC_WIDTH-1:0] v, logic neg);
    q15_t n;
    n = neg ? -v : v;
    if (n > UNIT_POS) begin
      return UNIT_POS;
    end
    if (n < UNIT_NEG) begin
      return UNIT_NEG;
    end
    return n;
  endfunction

  // divide by 2^15 toward zero
  function automatic coord_t trunc_q15(prod_t p);
    prod_t a;
    a = p + (p[PW-1] ? ROUND_ADJ : '0);
    a = a >>> FRAC_BITS;
    return a[OW-1:0];
  endfunction

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // stage a: sine and cosine
  coord_t ra;
  q15_t   saz;
  q15_t   caz;
  q15_t   salt;
  q15_t   calt_a;
  // stage b: first products
  prod_t  px;
  prod_t  pz;
  prod_t  py;
  q15_t   calt_b;
  // stage c: truncated
  coord_t tx;
  coord_t tz;
  coord_t ty;
  q15_t   calt_c;
  // stage d: second products
  prod_t  qx;
  prod_t  qz;
  coord_t yd;

  always_comb begin
    en[NS-1] = !v[NS-1] || cart.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      ra     <= coord_t'({1'b0, radius});
      saz    <= fix(az.y, az.neg);
      caz    <= fix(az.x, az.neg);
      salt   <= fix(alt.y, alt.neg);
      calt_a <= fix(alt.x, alt.neg);
    end
    if (en[1] && v[0]) begin
      px     <= prod_t'(ra) * prod_t'(saz);
      pz     <= prod_t'(ra) * prod_t'(caz);
      py     <= prod_t'(ra) * prod_t'(salt);
      calt_b <= calt_a;
    end
    if (en[2] && v[1]) begin
      tx     <= trunc_q15(px);
      tz     <= trunc_q15(pz);
      ty     <= -trunc_q15(py);
      calt_c <= calt_b;
    end
    if (en[3] && v[2]) begin
      qx <= prod_t'(tx) * prod_t'(calt_c);
      qz <= prod_t'(tz) * prod_t'(calt_c);
      yd <= ty;
    end
    if (en[4] && v[3]) begin
      cart.coord_x <= trunc_q15(qx);
      cart.coord_z <= trunc_q15(qz);
      cart.coord_y <= yd;
    end
  end

  assign cart.valid = v[NS-1];

endmodule

// File: rtl/core/spherical_to_cartesian_top.sv
// top level of the spherical to cartesian converter
//
//  channel  dir  payload                               transaction
//  polar    in   radius, azimuth, altitude             one point, Q8.8 radius, binary angles
//  cart     out  coord_x, coord_y, coord_z             one point, signed Q8.8
//
// one transaction per cycle in and out, sustained while cart holds ready, set by the row of cordic cells
// the path is the fold register, one cell per iteration, then
// clamp, two multiply steps and two truncation steps ending in the output register
// rst is synchronous and clears only the valid flags, no clearing pass
// every stage moves when it is empty or its successor moves, so bubbles collapse
// and a stall at cart holds every full stage through the combinational ready chain
module spherical_to_cartesian_top
  import s2c_pkg::*;
#(
  parameter int ITERATIONS   = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int RADIUS_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  s2c_in_if.sink    polar,
  s2c_out_if.source cart
);

  localparam int N_CELL = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam logic signed [PHASE_WIDTH:0] QUARTER = 33'sd1073741824;
  localparam logic signed [PHASE_WIDTH:0] HALF    = 33'sd2147483648;

  // widen a binary angle to a 32 bit phase and fold it into a quarter turn
  // either side of zero; the flag says sin and cos must be negated
  function automatic s2c_lane_t fold(logic [ANGLE_WIDTH-1:0] a);
    s2c_lane_t                    l;
    logic signed [PHASE_WIDTH:0]  p;
    logic signed [PHASE_WIDTH:0]  q;
    p = {a[ANGLE_WIDTH-1], a, {(PHASE_WIDTH - ANGLE_WIDTH){1'b0}}};
    q = p;
    l.neg = 1'b0;
    if (p > QUARTER) begin
      q     = p - HALF;
      l.neg = 1'b1;
    end else if (p < -QUARTER) begin
      q     = p + HALF;
      l.neg = 1'b1;
    end
    l.phase = q[PHASE_WIDTH-1:0];
    l.x     = CORDIC_GAIN;
    l.y     = '0;
    return l;
  endfunction

  // fold register in front of the cells
  logic                    fold_valid;
  logic                    fold_ready;
  logic [RADIUS_WIDTH-1:0] fold_radius;
  s2c_lane_t               fold_az;
  s2c_lane_t               fold_alt;

  // chain wiring, entry k feeds cell k
  logic                    chain_valid  [N_CELL+1];
  logic                    chain_ready  [N_CELL+1];
  logic [RADIUS_WIDTH-1:0] chain_radius [N_CELL+1];
  s2c_lane_t               chain_az     [N_CELL+1];
  s2c_lane_t               chain_alt    [N_CELL+1];

  assign polar.ready = !fold_valid || fold_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (polar.ready) begin
      fold_valid <= polar.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (polar.ready && polar.valid) begin
      fold_radius <= polar.radius;
      fold_az     <= fold(polar.azimuth);
      fold_alt    <= fold(polar.altitude);
    end
  end

  assign chain_valid[0]  = fold_valid;
  assign fold_ready      = chain_ready[0];
  assign chain_radius[0] = fold_radius;
  assign chain_az[0]     = fold_az;
  assign chain_alt[0]    = fold_alt;

  // one rotation per cell, the shift and arctangent fixed by position
  for (genvar k = 0; k < N_CELL; k++) begin : g_cell
    s2c_cell #(
      .STAGE        (k),
      .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (chain_valid[k]),
      .in_ready   (chain_ready[k]),
      .in_radius  (chain_radius[k]),
      .in_az      (chain_az[k]),
      .in_alt     (chain_alt[k]),
      .out_valid  (chain_valid[k+1]),
      .out_ready  (chain_ready[k+1]),
      .out_radius (chain_radius[k+1]),
      .out_az     (chain_az[k+1]),
      .out_alt    (chain_alt[k+1])
    );
  end

  // sin/cos cleanup, products and the output register
  s2c_scale #(
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[N_CELL]),
    .in_ready (chain_ready[N_CELL]),
    .radius   (chain_radius[N_CELL]),
    .az       (chain_az[N_CELL]),
    .alt      (chain_alt[N_CELL]),
    .cart     (cart)
  );

  // truncation keeps every coordinate within the radius, never the most negative code
  a_no_min_code : assert property (@(posedge clk) disable iff (rst)
    cart.valid |-> (cart.coord_x != {1'b1, {RADIUS_WIDTH{1'b0}}}) &&
                   (cart.coord_y != {1'b1, {RADIUS_WIDTH{1'b0}}}) &&
                   (cart.coord_z != {1'b1, {RADIUS_WIDTH{1'b0}}}))
    else $error("coordinate outside radius range");

  // an empty fold register always takes a transaction
  a_front_open : assert property (@(posedge clk) disable iff (rst)
    !fold_valid |-> polar.ready)
    else $error("input blocked with empty front stage");

  // a stalled item at the end of the cell row is not dropped
  a_chain_hold : assert property (@(posedge clk) disable iff (rst)
    chain_valid[N_CELL] && !chain_ready[N_CELL] |=> chain_valid[N_CELL])
    else $error("item lost at end of cordic row");

  // nothing comes out in the cycle after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !cart.valid)
    else $error("output valid right after reset");

endmodule

// File: dv/tb_spherical_to_cartesian_top.sv
// self-checking testbench for the spherical to cartesian converter
module tb_spherical_to_cartesian_top;
  import s2c_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITERATIONS   = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int RADIUS_WIDTH = 16;
  localparam int OUT_WIDTH    = RADIUS_WIDTH + 1;
  // fold register, one cell per iteration, clamp, two multiplies, two truncations
  localparam int LATENCY      = ITERATIONS + 6;

  // phases in the 32-bit domain, one turn is 2^32
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint START_GAIN   = 64'sd19898;
  localparam longint UNIT_Q15     = 64'sd32768;

  // binary angles of the fold boundaries, 16-bit scale
  localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = 16'h4000;
  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = 16'h8000;
  localparam logic [ANGLE_WIDTH-1:0] ANG_NEG_QTR = 16'hC000;

  // rotation step per iteration, atan(2^-i), one turn is 2^32
  localparam longint ROT_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680350, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic [OUT_WIDTH-1:0] x;
    logic [OUT_WIDTH-1:0] y;
    logic [OUT_WIDTH-1:0] z;
  } cart_point_t;

  logic clk;
  logic rst;

  s2c_in_if  #(.RADIUS_WIDTH(RADIUS_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) polar_if ();
  s2c_out_if #(.RADIUS_WIDTH(RADIUS_WIDTH)) cart_if ();

  spherical_to_cartesian_top #(
    .ITERATIONS  (ITERATIONS),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .RADIUS_WIDTH(RADIUS_WIDTH)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .polar(polar_if),
    .cart (cart_if)
  );

  // points the converter still owes us, oldest first
  cart_point_t expected_points [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  // cycles the output side still has to hold off, counted down by the receiver
  int          hold_left;

  // -------------------------------------------------------------------------
  // clock and run limit
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, set far beyond the slowest legal run
  initial begin
    #400us;
    $display("TEST FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------

  // unrolled rotation-mode cordic on a binary angle, q1.15 sine and cosine
  function automatic void cordic_sin_cos(input logic [ANGLE_WIDTH-1:0] ang,
                                         output longint sin_q15,
                                         output longint cos_q15);
    longint ph;
    longint vx;
    longint vy;
    longint nx;
    bit     flip;
    int     i;
    ph   = longint'($signed({ang, {(32 - ANGLE_WIDTH){1'b0}}}));
    vx   = START_GAIN;
    vy   = 0;
    flip = 1'b0;
    // bring the phase within a quarter turn of zero, exact quarter stays put
    if (ph > QUARTER_TURN) begin
      ph   = ph - HALF_TURN;
      flip = 1'b1;
    end else if (ph < -QUARTER_TURN) begin
      ph   = ph + HALF_TURN;
      flip = 1'b1;
    end
    for (i = 0; i < ITERATIONS && i < 24; i++) begin
      if (ph >= 0) begin
        nx = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        ph = ph - ROT_STEP[i];
      end else begin
        nx = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        ph = ph + ROT_STEP[i];
      end
      vx = nx;
    end
    if (flip) begin
      vx = -vx;
      vy = -vy;
    end
    sin_q15 = (vy > UNIT_Q15) ? UNIT_Q15 : (vy < -UNIT_Q15) ? -UNIT_Q15 : vy;
    cos_q15 = (vx > UNIT_Q15) ? UNIT_Q15 : (vx < -UNIT_Q15) ? -UNIT_Q15 : vx;
  endfunction

  // product with a q1.15 factor, rounded toward zero
  function automatic longint scale_q15(input longint a, input longint b);
    return (a * b) / 32768;
  endfunction

  function automatic cart_point_t polar_to_cart(input logic [RADIUS_WIDTH-1:0] radius,
                                                input logic [ANGLE_WIDTH-1:0]  azimuth,
                                                input logic [ANGLE_WIDTH-1:0]  altitude);
    cart_point_t pt;
    longint      r;
    longint      s_az;
    longint      c_az;
    longint      s_alt;
    longint      c_alt;
    longint      vx;
    longint      vy;
    longint      vz;
    r = longint'(radius);
    cordic_sin_cos(azimuth, s_az, c_az);
    cordic_sin_cos(altitude, s_alt, c_alt);
    vx = scale_q15(scale_q15(r, s_az), c_alt);
    vy = -scale_q15(r, s_alt);
    vz = scale_q15(scale_q15(r, c_az), c_alt);
    pt.x = vx[OUT_WIDTH-1:0];
    pt.y = vy[OUT_WIDTH-1:0];
    pt.z = vz[OUT_WIDTH-1:0];
    return pt;
  endfunction

  // -------------------------------------------------------------------------
  // scoreboard: predict on every input transaction, compare every output one
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cart_point_t want;
    if (!rst) begin
      if (polar_if.valid && polar_if.ready)
        expected_points.push_back(polar_to_cart(polar_if.radius, polar_if.azimuth,
                                                polar_if.altitude));
      if (cart_if.valid && cart_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("cart transaction with nothing pending: x=%0d y=%0d z=%0d",
                 cart_if.coord_x, cart_if.coord_y, cart_if.coord_z);
          error_count++;
        end else begin
          want = expected_points.pop_front();
          if (cart_if.coord_x !== want.x) begin
            $error("coord_x expected %0d actual %0d", $signed(want.x), cart_if.coord_x);
            error_count++;
          end
          if (cart_if.coord_y !== want.y) begin
            $error("coord_y expected %0d actual %0d", $signed(want.y), cart_if.coord_y);
            error_count++;
          end
          if (cart_if.coord_z !== want.z) begin
            $error("coord_z expected %0d actual %0d", $signed(want.z), cart_if.coord_z);
            error_count++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // output side: random back-pressure, plus a long hold-off when asked
  // -------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        cart_if.ready <= 1'b0;
        hold_left--;
      end else begin
        cart_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // input side
  // -------------------------------------------------------------------------

  // offer one point, return once it has been taken; valid stays high for the next
  task automatic send_point(input logic [RADIUS_WIDTH-1:0] radius,
                            input logic [ANGLE_WIDTH-1:0]  azimuth,
                            input logic [ANGLE_WIDTH-1:0]  altitude);
    while ($urandom_range(99) < send_idle_pct) begin
      polar_if.valid <= 1'b0;
      @(posedge clk);
    end
    polar_if.valid    <= 1'b1;
    polar_if.radius   <= radius;
    polar_if.azimuth  <= azimuth;
    polar_if.altitude <= altitude;
    @(posedge clk);
    while (!polar_if.ready) @(posedge clk);
  endtask

  // angle a couple of steps away from one of the four quadrant boundaries
  function automatic logic [ANGLE_WIDTH-1:0] near_boundary();
    return ANGLE_WIDTH'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
  endfunction

  // uniform points, more than half with an extreme radius or an angle at the folds
  task automatic send_random_point();
    logic [RADIUS_WIDTH-1:0] r;
    logic [ANGLE_WIDTH-1:0]  az;
    logic [ANGLE_WIDTH-1:0]  alt;
    int                      pick;
    r    = RADIUS_WIDTH'($urandom);
    az   = ANGLE_WIDTH'($urandom);
    alt  = ANGLE_WIDTH'($urandom);
    pick = $urandom_range(9);
    case (pick)
      0: r = '1;
      1: r = RADIUS_WIDTH'($urandom_range(3));
      2, 3: az = near_boundary();
      4, 5: alt = near_boundary();
      default: ;
    endcase
    send_point(r, az, alt);
  endtask

  task automatic wait_for_drain();
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // field extremes, exact and just-past quarter turns, half turn, bit patterns
  task automatic test_directed_extremes();
    send_point(16'h0000, 16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'h0000, 16'h0000);
    send_point(16'hFFFF, ANG_QUARTER, 16'h0000);
    send_point(16'hFFFF, ANG_QUARTER + 16'd1, 16'h0000);
    send_point(16'hFFFF, ANG_QUARTER - 16'd1, 16'h0000);
    send_point(16'hFFFF, ANG_HALF, 16'h0000);
    send_point(16'hFFFF, ANG_NEG_QTR, 16'h0000);
    send_point(16'hFFFF, ANG_NEG_QTR - 16'd1, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF, 16'h0000);
    send_point(16'hFFFF, 16'h0000, ANG_QUARTER);
    send_point(16'hFFFF, 16'h0000, ANG_NEG_QTR);
    send_point(16'hFFFF, 16'h0000, ANG_QUARTER + 16'd1);
    send_point(16'hFFFF, 16'h0000, ANG_NEG_QTR - 16'd1);
    send_point(16'hFFFF, 16'h0000, ANG_HALF);
    send_point(16'hFFFF, 16'h0000, 16'h7FFF);
    send_point(16'hFFFF, 16'h2000, 16'h2000);
    send_point(16'h0100, 16'h6000, 16'hE000);
    send_point(16'h0001, 16'hA000, 16'd12345);
    send_point(16'h8000, 16'd12345, 16'hB1E0);
    send_point(16'hFFFF, ANG_QUARTER - 16'd1, ANG_QUARTER - 16'd1);
    send_point(16'hAAAA, 16'h5555, 16'hAAAA);
    send_point(16'h5555, 16'hAAAA, 16'h5555);
  endtask

  task automatic test_random_points(input int count, input int send_pct, input int recv_pct);
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (n = 0; n < count; n++) send_random_point();
  endtask

  // output held off long enough that the pipeline fills and polar stalls
  task automatic test_output_hold();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 4 * LATENCY + 100;
    for (n = 0; n < 120; n++) send_random_point();
  endtask

  // bursts separated by full drains of the pipeline
  task automatic test_drain_pauses();
    int burst;
    int n;
    send_idle_pct = 10;
    recv_idle_pct = 30;
    for (burst = 0; burst < 4; burst++) begin
      for (n = 0; n < 20; n++) send_random_point();
      polar_if.valid <= 1'b0;
      @(posedge clk);
      wait_for_drain();
    end
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    error_count        = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    hold_left          = 0;
    rst               <= 1'b1;
    polar_if.valid    <= 1'b0;
    polar_if.radius   <= '0;
    polar_if.azimuth  <= '0;
    polar_if.altitude <= '0;
    cart_if.ready     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    // sender idles lightly, receiver heavily, then swapped, then flat out
    test_random_points(400, 25, 55);
    test_random_points(400, 55, 25);
    test_random_points(400, 0, 0);
    test_output_hold();
    test_drain_pauses();

    polar_if.valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_for_drain();
    // let any stray transaction surface before the verdict
    repeat (2 * LATENCY) @(posedge clk);

    if (error_count == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: spherical_to_cartesian_top.f
rtl/core/s2c_pkg.sv
rtl/core/s2c_if.sv
rtl/core/s2c_cell.sv
rtl/core/s2c_scale.sv
rtl/core/spherical_to_cartesian_top.sv
dv/tb_spherical_to_cartesian_top.sv
